// ----- sv/lec_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// LED effect controller package
// Shared constants, codes and payload types of the LED effect controller.
// ----------------------------------------------------------------------------
package lec_pkg;

   localparam int PATTERN_DEPTH    = 16;
   localparam int TIME_BITS        = 16;
   localparam int ADDR_BITS        = $clog2(PATTERN_DEPTH);
   localparam int POS_BITS         = ADDR_BITS + 1;
   localparam int ELAPSED_BITS     = TIME_BITS + 1;
   localparam int ENTRY_INDEX_BITS = 4;
   localparam int CMD_BITS         = 3;
   localparam int LED_MODE_BITS    = 3;
   localparam int DUTY_BITS        = 8;
   localparam int CSR_INDEX_BITS   = 3;
   localparam int CSR_DATA_BITS    = TIME_BITS;
   localparam logic [DUTY_BITS-1:0] DUTY_MAX = 8'd255;

   typedef enum logic [CMD_BITS-1:0] {
      CMD_TICK   = 3'd0,
      CMD_ON     = 3'd1,
      CMD_OFF    = 3'd2,
      CMD_TOGGLE = 3'd3,
      CMD_START  = 3'd4,
      CMD_LOAD   = 3'd5
   } cmd_type;

   typedef enum logic [LED_MODE_BITS-1:0] {
      MODE_MANUAL  = 3'd0,
      MODE_BLINK   = 3'd1,
      MODE_BREATHE = 3'd2,
      MODE_PULSE   = 3'd3,
      MODE_PATTERN = 3'd4,
      MODE_PWM     = 3'd5
   } led_mode_type;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_LED_MODE       = 3'd0,
      CSR_TIME_ON        = 3'd1,
      CSR_TIME_OFF       = 3'd2,
      CSR_BREATHE_PERIOD = 3'd3,
      CSR_PULSE_LENGTH   = 3'd4,
      CSR_PWM_LEVEL      = 3'd5
   } csr_index_type;

   typedef enum logic [1:0] {
      SRC_ZERO,
      SRC_MEM,
      SRC_WRITE
   } rd_src_type;

   typedef struct packed {
      logic [CMD_BITS-1:0]         mode;
      logic [ENTRY_INDEX_BITS-1:0] entry_index;
      logic [TIME_BITS-1:0]        entry_duration;
   } req_payload_type;

   typedef struct packed {
      logic                 led_lit;
      logic [DUTY_BITS-1:0] pwm_duty;
      logic                 pwm_active;
      logic                 effect_busy;
   } rsp_payload_type;

   typedef struct packed {
      logic                 wr_en;
      logic [ADDR_BITS-1:0] wr_addr;
      logic [TIME_BITS-1:0] wr_data;
      logic [ADDR_BITS-1:0] rd_addr_cur;
      logic [ADDR_BITS-1:0] rd_addr_nxt;
   } tbl_access_type;

   typedef struct packed {
      logic [TIME_BITS-1:0] cur_dur;
      logic [TIME_BITS-1:0] nxt_dur;
   } tbl_read_type;

endpackage
`default_nettype wire

// ----- sv/lec_pattern_mem.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Pattern table memory
// Duration table, one write port and two registered read ports. Entries not
// yet written since reset read as zero; a write to a read address forwards.
// ----------------------------------------------------------------------------
module lec_pattern_mem (
   input  wire                    clock,
   input  wire                    reset,
   input  lec_pkg::tbl_access_type acc,
   output lec_pkg::tbl_read_type   rd
);

   logic [lec_pkg::TIME_BITS-1:0]     entry_mem_ff [lec_pkg::PATTERN_DEPTH];
   logic [lec_pkg::PATTERN_DEPTH-1:0] valid_ff;
   logic [lec_pkg::TIME_BITS-1:0]     raw_cur_ff;
   logic [lec_pkg::TIME_BITS-1:0]     raw_nxt_ff;
   logic [lec_pkg::TIME_BITS-1:0]     wdata_ff;
   lec_pkg::rd_src_type               src_cur_ff;
   lec_pkg::rd_src_type               src_nxt_ff;
   lec_pkg::rd_src_type               src_cur_in;
   lec_pkg::rd_src_type               src_nxt_in;

   always_ff @(posedge clock) begin
      if (acc.wr_en) begin
         entry_mem_ff[acc.wr_addr] <= acc.wr_data;
      end
      raw_cur_ff <= entry_mem_ff[acc.rd_addr_cur];
      raw_nxt_ff <= entry_mem_ff[acc.rd_addr_nxt];
      wdata_ff   <= acc.wr_data;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (acc.wr_en) begin
         valid_ff[acc.wr_addr] <= 1'b1;
      end
   end

   always_comb begin
      if (acc.wr_en && acc.wr_addr == acc.rd_addr_cur) begin
         src_cur_in = lec_pkg::SRC_WRITE;
      end else if (valid_ff[acc.rd_addr_cur]) begin
         src_cur_in = lec_pkg::SRC_MEM;
      end else begin
         src_cur_in = lec_pkg::SRC_ZERO;
      end
      if (acc.wr_en && acc.wr_addr == acc.rd_addr_nxt) begin
         src_nxt_in = lec_pkg::SRC_WRITE;
      end else if (valid_ff[acc.rd_addr_nxt]) begin
         src_nxt_in = lec_pkg::SRC_MEM;
      end else begin
         src_nxt_in = lec_pkg::SRC_ZERO;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         src_cur_ff <= lec_pkg::SRC_ZERO;
         src_nxt_ff <= lec_pkg::SRC_ZERO;
      end else begin
         src_cur_ff <= src_cur_in;
         src_nxt_ff <= src_nxt_in;
      end
   end

   always_comb begin
      case (src_cur_ff)
         lec_pkg::SRC_MEM:   rd.cur_dur = raw_cur_ff;
         lec_pkg::SRC_WRITE: rd.cur_dur = wdata_ff;
         default:            rd.cur_dur = '0;
      endcase
      case (src_nxt_ff)
         lec_pkg::SRC_MEM:   rd.nxt_dur = raw_nxt_ff;
         lec_pkg::SRC_WRITE: rd.nxt_dur = wdata_ff;
         default:            rd.nxt_dur = '0;
      endcase
   end

endmodule
`default_nettype wire

// ----- sv/lec_effect_core.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Effect engine
// Configuration registers and effect state; updates the state for one accepted
// request per cycle and forms its response. Pattern durations at the current
// and following position come prefetched from the pattern table memory.
// ----------------------------------------------------------------------------
module lec_effect_core (
   input  wire                                    clock,
   input  wire                                    reset,
   input  wire                                    req_accept,
   input  lec_pkg::req_payload_type               req_data,
   input  wire                                    csr_write_en,
   input  wire  [lec_pkg::CSR_INDEX_BITS-1:0]     csr_index,
   input  wire  [lec_pkg::CSR_DATA_BITS-1:0]      csr_wdata,
   input  lec_pkg::tbl_read_type                  rd,
   output lec_pkg::tbl_access_type                acc,
   output logic                                   push_valid,
   output lec_pkg::rsp_payload_type               push_data
);

   localparam logic [lec_pkg::POS_BITS-1:0] DEPTH_POS =
      lec_pkg::POS_BITS'(lec_pkg::PATTERN_DEPTH);

   logic [lec_pkg::LED_MODE_BITS-1:0] led_mode_ff;
   logic [lec_pkg::TIME_BITS-1:0]     time_on_ff;
   logic [lec_pkg::TIME_BITS-1:0]     time_off_ff;
   logic [lec_pkg::TIME_BITS-1:0]     breathe_period_ff;
   logic [lec_pkg::TIME_BITS-1:0]     pulse_length_ff;
   logic [lec_pkg::DUTY_BITS-1:0]     pwm_level_ff;

   logic                              lit_ff, lit_in;
   logic [lec_pkg::ELAPSED_BITS-1:0]  elapsed_ff, elapsed_in;
   logic [lec_pkg::DUTY_BITS-1:0]     level_ff, level_in;
   logic                              rising_ff, rising_in;
   logic [lec_pkg::ELAPSED_BITS-1:0]  breathe_elapsed_ff, breathe_elapsed_in;
   logic                              pulse_ff, pulse_in;
   logic                              pattern_ff, pattern_in;
   logic [lec_pkg::POS_BITS-1:0]      pos_ff, pos_in;

   logic [lec_pkg::ELAPSED_BITS-1:0]  elapsed_inc;
   logic [lec_pkg::ELAPSED_BITS-1:0]  breathe_inc;
   logic [lec_pkg::POS_BITS-1:0]      pos_inc;
   logic [lec_pkg::POS_BITS-1:0]      pos_in_inc;
   logic                              rising_step;
   logic [lec_pkg::DUTY_BITS-1:0]     level_step;
   logic                              load_ok;

   // Hold configuration; the user must write only while idle, the block itself does not enforce it.
   always_ff @(posedge clock) begin
      if (reset) begin
         led_mode_ff       <= lec_pkg::MODE_MANUAL;
         time_on_ff        <= lec_pkg::TIME_BITS'(500);
         time_off_ff       <= lec_pkg::TIME_BITS'(500);
         breathe_period_ff <= lec_pkg::TIME_BITS'(10);
         pulse_length_ff   <= lec_pkg::TIME_BITS'(100);
         pwm_level_ff      <= '0;
      end else if (csr_write_en) begin
         case (csr_index)
            lec_pkg::CSR_LED_MODE:
               led_mode_ff <= csr_wdata[lec_pkg::LED_MODE_BITS-1:0];
            lec_pkg::CSR_TIME_ON:        time_on_ff        <= csr_wdata;
            lec_pkg::CSR_TIME_OFF:       time_off_ff       <= csr_wdata;
            lec_pkg::CSR_BREATHE_PERIOD: breathe_period_ff <= csr_wdata;
            lec_pkg::CSR_PULSE_LENGTH:   pulse_length_ff   <= csr_wdata;
            lec_pkg::CSR_PWM_LEVEL:
               pwm_level_ff <= csr_wdata[lec_pkg::DUTY_BITS-1:0];
            default: ;
         endcase
      end
   end

   assign elapsed_inc = (elapsed_ff == '1) ? elapsed_ff
                        : lec_pkg::ELAPSED_BITS'(elapsed_ff + 1'b1);
   assign breathe_inc = (breathe_elapsed_ff == '1) ? breathe_elapsed_ff
                        : lec_pkg::ELAPSED_BITS'(breathe_elapsed_ff + 1'b1);
   assign pos_inc     = lec_pkg::POS_BITS'(pos_ff + 1'b1);
   assign rising_step = (level_ff == lec_pkg::DUTY_MAX) ? 1'b0
                        : (level_ff == '0) ? 1'b1 : rising_ff;
   assign level_step  = rising_step ? lec_pkg::DUTY_BITS'(level_ff + 1'b1)
                        : lec_pkg::DUTY_BITS'(level_ff - 1'b1);
   assign load_ok     = int'(req_data.entry_index) < lec_pkg::PATTERN_DEPTH;

   always_comb begin
      lit_in             = lit_ff;
      elapsed_in         = elapsed_ff;
      level_in           = level_ff;
      rising_in          = rising_ff;
      breathe_elapsed_in = breathe_elapsed_ff;
      pulse_in           = pulse_ff;
      pattern_in         = pattern_ff;
      pos_in             = pos_ff;
      acc.wr_en          = 1'b0;
      acc.wr_addr        = lec_pkg::ADDR_BITS'(req_data.entry_index);
      acc.wr_data        = req_data.entry_duration;
      if (req_accept) begin
         case (req_data.mode)
            lec_pkg::CMD_TICK: begin
               elapsed_in = elapsed_inc;
               case (led_mode_ff)
                  lec_pkg::MODE_BLINK: begin
                     if (lit_ff) begin
                        if (elapsed_inc > lec_pkg::ELAPSED_BITS'(time_on_ff)) begin
                           lit_in     = 1'b0;
                           elapsed_in = '0;
                        end
                     end else if (elapsed_inc > lec_pkg::ELAPSED_BITS'(time_off_ff)) begin
                        lit_in     = 1'b1;
                        elapsed_in = '0;
                     end
                  end
                  lec_pkg::MODE_BREATHE: begin
                     if (breathe_inc > lec_pkg::ELAPSED_BITS'(breathe_period_ff)) begin
                        rising_in          = rising_step;
                        level_in           = level_step;
                        breathe_elapsed_in = '0;
                     end else begin
                        breathe_elapsed_in = breathe_inc;
                     end
                  end
                  lec_pkg::MODE_PULSE: begin
                     if (pulse_ff &&
                         elapsed_inc > lec_pkg::ELAPSED_BITS'(pulse_length_ff)) begin
                        lit_in   = 1'b0;
                        pulse_in = 1'b0;
                     end
                  end
                  lec_pkg::MODE_PATTERN: begin
                     if (pattern_ff && pos_ff < DEPTH_POS &&
                         elapsed_inc > lec_pkg::ELAPSED_BITS'(rd.cur_dur)) begin
                        lit_in     = ~lit_ff;
                        elapsed_in = '0;
                        pos_in     = pos_inc;
                        if (pos_inc >= DEPTH_POS || rd.nxt_dur == '0) begin
                           lit_in     = 1'b0;
                           pattern_in = 1'b0;
                        end
                     end
                  end
                  default: ;
               endcase
            end
            lec_pkg::CMD_ON:     lit_in = 1'b1;
            lec_pkg::CMD_OFF:    lit_in = 1'b0;
            lec_pkg::CMD_TOGGLE: lit_in = ~lit_ff;
            lec_pkg::CMD_START: begin
               if (led_mode_ff == lec_pkg::MODE_PULSE) begin
                  lit_in     = 1'b1;
                  elapsed_in = '0;
                  pulse_in   = 1'b1;
               end else if (led_mode_ff == lec_pkg::MODE_PATTERN) begin
                  pos_in     = '0;
                  lit_in     = 1'b1;
                  elapsed_in = '0;
                  pattern_in = 1'b1;
               end
            end
            lec_pkg::CMD_LOAD: acc.wr_en = load_ok;
            default: ;
         endcase
      end
      // Prefetch durations for the position the next request will see.
      pos_in_inc = lec_pkg::POS_BITS'(pos_in + 1'b1);
      acc.rd_addr_cur = (pos_in < DEPTH_POS) ? lec_pkg::ADDR_BITS'(pos_in) : '0;
      acc.rd_addr_nxt = (pos_in_inc < DEPTH_POS) ? lec_pkg::ADDR_BITS'(pos_in_inc) : '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         lit_ff             <= 1'b0;
         elapsed_ff         <= '0;
         level_ff           <= '0;
         rising_ff          <= 1'b1;
         breathe_elapsed_ff <= '0;
         pulse_ff           <= 1'b0;
         pattern_ff         <= 1'b0;
         pos_ff             <= '0;
      end else begin
         lit_ff             <= lit_in;
         elapsed_ff         <= elapsed_in;
         level_ff           <= level_in;
         rising_ff          <= rising_in;
         breathe_elapsed_ff <= breathe_elapsed_in;
         pulse_ff           <= pulse_in;
         pattern_ff         <= pattern_in;
         pos_ff             <= pos_in;
      end
   end

   always_comb begin
      push_valid            = req_accept;
      push_data.led_lit     = lit_in;
      push_data.effect_busy = pulse_in | pattern_in;
      case (led_mode_ff)
         lec_pkg::MODE_BREATHE: begin
            push_data.pwm_duty   = level_in;
            push_data.pwm_active = 1'b1;
         end
         lec_pkg::MODE_PWM: begin
            push_data.pwm_duty   = pwm_level_ff;
            push_data.pwm_active = 1'b1;
         end
         default: begin
            push_data.pwm_duty   = '0;
            push_data.pwm_active = 1'b0;
         end
      endcase
   end

endmodule
`default_nettype wire

// ----- sv/lec_rsp_buffer.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Response buffer
// Two-entry output queue; keeps requests flowing while a response waits.
// ----------------------------------------------------------------------------
module lec_rsp_buffer (
   input  wire                       clock,
   input  wire                       reset,
   input  wire                       push_valid,
   input  lec_pkg::rsp_payload_type  push_data,
   output logic                      full,
   output logic                      rsp_valid,
   input  wire                       rsp_ready,
   output lec_pkg::rsp_payload_type  rsp_data
);

   logic [1:0]               count_ff, count_in;
   lec_pkg::rsp_payload_type head_ff, head_in;
   lec_pkg::rsp_payload_type tail_ff, tail_in;
   logic                     push;
   logic                     pop;

   assign full      = count_ff == 2'd2;
   assign rsp_valid = count_ff != 2'd0;
   assign rsp_data  = head_ff;
   assign push      = push_valid & ~full;
   assign pop       = rsp_valid & rsp_ready;

   always_comb begin
      count_in = count_ff;
      head_in  = head_ff;
      tail_in  = tail_ff;
      case ({push, pop})
         2'b10: begin
            if (count_ff == 2'd0) begin
               head_in = push_data;
            end else begin
               tail_in = push_data;
            end
            count_in = count_ff + 2'd1;
         end
         2'b01: begin
            head_in  = tail_ff;
            count_in = count_ff - 2'd1;
         end
         2'b11: begin
            if (count_ff == 2'd1) begin
               head_in = push_data;
            end else begin
               head_in = tail_ff;
               tail_in = push_data;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
      head_ff <= head_in;
      tail_ff <= tail_in;
   end

endmodule
`default_nettype wire

// ----- sv/led_effect_controller_core.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// LED effect controller
// Drives one LED from tick and command requests in manual, blink, breathe,
// pulse, pattern or fixed PWM mode.
// ----------------------------------------------------------------------------
// Takes one request every clock cycle while the response queue is not full and
// returns exactly one response per request. Each request is a single
// read-modify-write of the effect state registers; the pattern table sits in a
// synchronous memory whose two read ports are addressed each cycle from the
// next pattern position, so the durations for the current and following step
// are ready when the next request arrives. A two-entry response queue keeps
// req_ready high unless two responses are waiting. Configuration writes take
// effect at the next cycle and are expected only while no request is open.
// ----------------------------------------------------------------------------
module led_effect_controller_core (
   input  wire                                  clock,
   input  wire                                  reset,
   input  wire                                  req_valid,
   output logic                                 req_ready,
   input  lec_pkg::req_payload_type             req_data,
   output logic                                 rsp_valid,
   input  wire                                  rsp_ready,
   output lec_pkg::rsp_payload_type             rsp_data,
   input  wire                                  csr_write_en,
   input  wire  [lec_pkg::CSR_INDEX_BITS-1:0]   csr_index,
   input  wire  [lec_pkg::CSR_DATA_BITS-1:0]    csr_wdata
);

   logic                     req_accept;
   logic                     buf_full;
   logic                     push_valid;
   lec_pkg::rsp_payload_type push_data;
   lec_pkg::tbl_access_type  tbl_acc;
   lec_pkg::tbl_read_type    tbl_rd;

   assign req_ready  = ~buf_full;
   assign req_accept = req_valid & req_ready;

   lec_effect_core u_core (
      .clock        (clock),
      .reset        (reset),
      .req_accept   (req_accept),
      .req_data     (req_data),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata),
      .rd           (tbl_rd),
      .acc          (tbl_acc),
      .push_valid   (push_valid),
      .push_data    (push_data)
   );

   lec_pattern_mem u_mem (
      .clock (clock),
      .reset (reset),
      .acc   (tbl_acc),
      .rd    (tbl_rd)
   );

   lec_rsp_buffer u_rsp_buffer (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_data  (push_data),
      .full       (buf_full),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_data   (rsp_data)
   );

endmodule
`default_nettype wire

// ----- sv/lec_checker.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// LED effect controller port checker
// Port-level checks of response flow and output encoding.
// ----------------------------------------------------------------------------
module lec_checker (
   input wire                           clock,
   input wire                           reset,
   input wire                           req_valid,
   input wire                           req_ready,
   input wire                           rsp_valid,
   input wire                           rsp_ready,
   input lec_pkg::rsp_payload_type      rsp_data
);

   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid after reset");

   a_req_gives_rsp: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> rsp_valid)
      else $error("accepted request produced no response");

   a_full_holds: assert property (@(posedge clock) disable iff (reset)
      !req_ready && !(rsp_valid && rsp_ready) |=> !req_ready)
      else $error("queue space appeared without a response leaving");

   a_rsp_stall: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("stalled response changed");

   a_duty_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.pwm_active |-> rsp_data.pwm_duty == '0)
      else $error("duty nonzero while pwm inactive");

endmodule

bind led_effect_controller_core lec_checker u_lec_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_ready (req_ready),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);
`default_nettype wire

// ----- dv/led_effect_controller_core_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LED effect controller core testbench
// Sends tick and command requests under every LED mode and random register
// settings, predicts each response in a behavioral copy of the controller, and
// checks every response field in order with random stalls on both channels.
// ----------------------------------------------------------------------------
module led_effect_controller_core_tb;

   localparam logic [lec_pkg::CMD_BITS-1:0]      CMD_UNUSED_LO      = 3'd6;
   localparam logic [lec_pkg::CMD_BITS-1:0]      CMD_UNUSED_HI      = 3'd7;
   localparam logic [lec_pkg::LED_MODE_BITS-1:0] LED_MODE_UNUSED_LO = 3'd6;
   localparam int LONG_IDLE_TICKS  = 40;
   localparam int PHASE_COUNT      = 14;
   localparam int PHASE_REQUESTS   = 30;
   localparam int BOUNCE_TICKS     = 540;
   localparam int MAX_IDLE         = 11;

   logic                               clock = 1'b0;
   logic                               reset = 1'b1;
   logic                               req_valid = 1'b0;
   logic                               req_ready;
   lec_pkg::req_payload_type           req_data = '0;
   logic                               rsp_valid;
   logic                               rsp_ready = 1'b0;
   lec_pkg::rsp_payload_type           rsp_data;
   logic                               csr_write_en = 1'b0;
   logic [lec_pkg::CSR_INDEX_BITS-1:0] csr_index = '0;
   logic [lec_pkg::CSR_DATA_BITS-1:0]  csr_wdata = '0;

   // controller register copy
   logic [lec_pkg::LED_MODE_BITS-1:0]  cfg_led_mode;
   logic [lec_pkg::TIME_BITS-1:0]      cfg_time_on;
   logic [lec_pkg::TIME_BITS-1:0]      cfg_time_off;
   logic [lec_pkg::TIME_BITS-1:0]      cfg_breathe_period;
   logic [lec_pkg::TIME_BITS-1:0]      cfg_pulse_length;
   logic [lec_pkg::DUTY_BITS-1:0]      cfg_pwm_level;

   // effect state copy
   logic                               lit_state;
   logic [lec_pkg::ELAPSED_BITS-1:0]   elapsed_count;
   logic [lec_pkg::DUTY_BITS-1:0]      breathe_duty;
   logic                               breathe_up;
   logic [lec_pkg::ELAPSED_BITS-1:0]   breathe_count;
   logic                               pulse_on;
   logic                               pattern_on;
   logic [lec_pkg::POS_BITS-1:0]       pattern_step;
   logic [lec_pkg::TIME_BITS-1:0]      pattern_durations [lec_pkg::PATTERN_DEPTH];

   lec_pkg::rsp_payload_type           expected_responses [$];
   int unsigned                        idle_max = MAX_IDLE;
   int unsigned                        mismatch_count = 0;
   int unsigned                        requests_sent = 0;
   int unsigned                        responses_checked = 0;
   int unsigned                        phases_run = 0;

   led_effect_controller_core dut (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_data     (req_data),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_data     (rsp_data),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata)
   );

   always #5 clock = ~clock;

   task automatic reset_led_model();
      cfg_led_mode       = lec_pkg::MODE_MANUAL;
      cfg_time_on        = 16'd500;
      cfg_time_off       = 16'd500;
      cfg_breathe_period = 16'd10;
      cfg_pulse_length   = 16'd100;
      cfg_pwm_level      = '0;
      lit_state          = 1'b0;
      elapsed_count      = '0;
      breathe_duty       = '0;
      breathe_up         = 1'b1;
      breathe_count      = '0;
      pulse_on           = 1'b0;
      pattern_on         = 1'b0;
      pattern_step       = '0;
      for (int i = 0; i < lec_pkg::PATTERN_DEPTH; i++) pattern_durations[i] = '0;
   endtask

   function automatic logic [lec_pkg::ELAPSED_BITS-1:0] saturate_inc(
      input logic [lec_pkg::ELAPSED_BITS-1:0] v);
      return (&v) ? v : v + 1'b1;
   endfunction

   function automatic void advance_tick();
      elapsed_count = saturate_inc(elapsed_count);
      case (cfg_led_mode)
         lec_pkg::MODE_BLINK: begin
            if (lit_state) begin
               if (elapsed_count > cfg_time_on) begin
                  lit_state     = 1'b0;
                  elapsed_count = '0;
               end
            end else if (elapsed_count > cfg_time_off) begin
               lit_state     = 1'b1;
               elapsed_count = '0;
            end
         end
         lec_pkg::MODE_BREATHE: begin
            breathe_count = saturate_inc(breathe_count);
            if (breathe_count > cfg_breathe_period) begin
               if (breathe_duty == lec_pkg::DUTY_MAX) breathe_up = 1'b0;
               else if (breathe_duty == '0) breathe_up = 1'b1;
               breathe_duty  = breathe_up ? breathe_duty + 1'b1 : breathe_duty - 1'b1;
               breathe_count = '0;
            end
         end
         lec_pkg::MODE_PULSE: begin
            if (pulse_on && elapsed_count > cfg_pulse_length) begin
               lit_state = 1'b0;
               pulse_on  = 1'b0;
            end
         end
         lec_pkg::MODE_PATTERN: begin
            if (pattern_on && pattern_step < lec_pkg::PATTERN_DEPTH &&
                elapsed_count >
                pattern_durations[pattern_step[lec_pkg::ADDR_BITS-1:0]]) begin
               lit_state     = ~lit_state;
               elapsed_count = '0;
               pattern_step  = pattern_step + 1'b1;
               if (pattern_step >= lec_pkg::PATTERN_DEPTH ||
                   pattern_durations[pattern_step[lec_pkg::ADDR_BITS-1:0]] == '0) begin
                  lit_state  = 1'b0;
                  pattern_on = 1'b0;
               end
            end
         end
         default: ;
      endcase
   endfunction

   function automatic lec_pkg::rsp_payload_type next_led_response(
      input lec_pkg::req_payload_type item);
      lec_pkg::rsp_payload_type result;
      case (item.mode)
         lec_pkg::CMD_TICK:   advance_tick();
         lec_pkg::CMD_ON:     lit_state = 1'b1;
         lec_pkg::CMD_OFF:    lit_state = 1'b0;
         lec_pkg::CMD_TOGGLE: lit_state = ~lit_state;
         lec_pkg::CMD_START: begin
            if (cfg_led_mode == lec_pkg::MODE_PULSE) begin
               lit_state     = 1'b1;
               elapsed_count = '0;
               pulse_on      = 1'b1;
            end else if (cfg_led_mode == lec_pkg::MODE_PATTERN) begin
               pattern_step  = '0;
               lit_state     = 1'b1;
               elapsed_count = '0;
               pattern_on    = 1'b1;
            end
         end
         lec_pkg::CMD_LOAD:   pattern_durations[item.entry_index] = item.entry_duration;
         default: ;
      endcase
      result.led_lit     = lit_state;
      result.pwm_duty    = (cfg_led_mode == lec_pkg::MODE_BREATHE) ? breathe_duty :
                           (cfg_led_mode == lec_pkg::MODE_PWM) ? cfg_pwm_level : '0;
      result.pwm_active  = (cfg_led_mode == lec_pkg::MODE_BREATHE) ||
                           (cfg_led_mode == lec_pkg::MODE_PWM);
      result.effect_busy = pulse_on || pattern_on;
      return result;
   endfunction

   function automatic lec_pkg::req_payload_type make_request(
      input logic [lec_pkg::CMD_BITS-1:0]         cmd,
      input logic [lec_pkg::ENTRY_INDEX_BITS-1:0] idx,
      input logic [lec_pkg::TIME_BITS-1:0]        dur);
      lec_pkg::req_payload_type item;
      item.mode           = cmd;
      item.entry_index    = idx;
      item.entry_duration = dur;
      return item;
   endfunction

   function automatic lec_pkg::req_payload_type random_request();
      lec_pkg::req_payload_type item;
      int unsigned              r;
      r = $urandom_range(0, 99);
      item.entry_index    =
         lec_pkg::ENTRY_INDEX_BITS'($urandom_range(0, lec_pkg::PATTERN_DEPTH - 1));
      item.entry_duration = lec_pkg::TIME_BITS'($urandom_range(0, 16'hFFFF));
      if (r < 55) item.mode = lec_pkg::CMD_TICK;
      else if (r < 62) item.mode = lec_pkg::CMD_START;
      else if (r < 74) begin
         item.mode = lec_pkg::CMD_LOAD;
         if ($urandom_range(0, 4) != 0)
            item.entry_duration = lec_pkg::TIME_BITS'($urandom_range(0, 5));
      end
      else if (r < 81) item.mode = lec_pkg::CMD_ON;
      else if (r < 88) item.mode = lec_pkg::CMD_OFF;
      else if (r < 95) item.mode = lec_pkg::CMD_TOGGLE;
      else item.mode = $urandom_range(0, 1) ? CMD_UNUSED_HI : CMD_UNUSED_LO;
      return item;
   endfunction

   function automatic logic [lec_pkg::TIME_BITS-1:0] pick_duration(
      input int unsigned short_max);
      int unsigned r;
      r = $urandom_range(0, 9);
      if (r == 0) return '0;
      if (r == 1) return '1;
      if (r == 2) return lec_pkg::TIME_BITS'($urandom_range(0, 16'hFFFF));
      return lec_pkg::TIME_BITS'($urandom_range(0, short_max));
   endfunction

   task automatic send_request(input lec_pkg::req_payload_type item);
      int unsigned gap;
      gap = $urandom_range(0, idle_max);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      @(posedge clock);
      while (req_ready !== 1'b1) @(posedge clock);
      expected_responses.push_back(next_led_response(item));
      requests_sent++;
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      while (expected_responses.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_register(input lec_pkg::csr_index_type idx,
                                 input logic [lec_pkg::CSR_DATA_BITS-1:0] data);
      @(posedge clock);
      csr_write_en <= 1'b1;
      csr_index    <= idx;
      csr_wdata    <= data;
      case (idx)
         lec_pkg::CSR_LED_MODE:       cfg_led_mode  = data[lec_pkg::LED_MODE_BITS-1:0];
         lec_pkg::CSR_TIME_ON:        cfg_time_on        = data;
         lec_pkg::CSR_TIME_OFF:       cfg_time_off       = data;
         lec_pkg::CSR_BREATHE_PERIOD: cfg_breathe_period = data;
         lec_pkg::CSR_PULSE_LENGTH:   cfg_pulse_length   = data;
         lec_pkg::CSR_PWM_LEVEL:      cfg_pwm_level = data[lec_pkg::DUTY_BITS-1:0];
         default: ;
      endcase
      @(posedge clock);
      csr_write_en <= 1'b0;
   endtask

   task automatic test_register_defaults();
      write_register(lec_pkg::CSR_LED_MODE, lec_pkg::CSR_DATA_BITS'(lec_pkg::MODE_PWM));
      send_request(make_request(lec_pkg::CMD_TICK, '0, '0));
      wait_drained();
      write_register(lec_pkg::CSR_LED_MODE, lec_pkg::CSR_DATA_BITS'(lec_pkg::MODE_BREATHE));
      repeat (11) send_request(make_request(lec_pkg::CMD_TICK, '0, '0));
      wait_drained();
   endtask

   task automatic test_directed_commands();
      write_register(lec_pkg::CSR_LED_MODE, lec_pkg::CSR_DATA_BITS'(lec_pkg::MODE_MANUAL));
      send_request(make_request(lec_pkg::CMD_ON, '0, '0));
      send_request(make_request(lec_pkg::CMD_TOGGLE, '0, '0));
      send_request(make_request(lec_pkg::CMD_TOGGLE, '0, '0));
      send_request(make_request(lec_pkg::CMD_OFF, '0, '0));
      send_request(make_request(CMD_UNUSED_LO, '1, '1));
      send_request(make_request(CMD_UNUSED_HI, '1, '1));
      send_request(make_request(lec_pkg::CMD_START, '0, '0));
      send_request(make_request(lec_pkg::CMD_LOAD, 4'd15, 16'hFFFF));
      send_request(make_request(lec_pkg::CMD_LOAD, 4'd0, 16'd1));
      send_request(make_request(lec_pkg::CMD_LOAD, 4'd1, 16'd0));
      wait_drained();
      write_register(lec_pkg::CSR_PULSE_LENGTH, '0);
      write_register(lec_pkg::CSR_LED_MODE, lec_pkg::CSR_DATA_BITS'(lec_pkg::MODE_PULSE));
      send_request(make_request(lec_pkg::CMD_START, '0, '0));
      send_request(make_request(lec_pkg::CMD_TICK, '0, '0));
      wait_drained();
      write_register(lec_pkg::CSR_LED_MODE, lec_pkg::CSR_DATA_BITS'(lec_pkg::MODE_PATTERN));
      send_request(make_request(lec_pkg::CMD_START, '0, '0));
      repeat (2) send_request(make_request(lec_pkg::CMD_TICK, '0, '0));
      wait_drained();
   endtask

   task automatic test_long_off_time();
      idle_max = 0;
      write_register(lec_pkg::CSR_LED_MODE, lec_pkg::CSR_DATA_BITS'(lec_pkg::MODE_MANUAL));
      send_request(make_request(lec_pkg::CMD_OFF, '0, '0));
      repeat (LONG_IDLE_TICKS) send_request(make_request(lec_pkg::CMD_TICK, '0, '0));
      wait_drained();
      write_register(lec_pkg::CSR_TIME_OFF, '1);
      write_register(lec_pkg::CSR_LED_MODE, lec_pkg::CSR_DATA_BITS'(lec_pkg::MODE_BLINK));
      repeat (2) send_request(make_request(lec_pkg::CMD_TICK, '0, '0));
      wait_drained();
      idle_max = MAX_IDLE;
   endtask

   task automatic test_breathe_bounce();
      write_register(lec_pkg::CSR_BREATHE_PERIOD, '0);
      write_register(lec_pkg::CSR_LED_MODE, lec_pkg::CSR_DATA_BITS'(lec_pkg::MODE_BREATHE));
      repeat (BOUNCE_TICKS)
         send_request(make_request(lec_pkg::CMD_TICK,
                                   lec_pkg::ENTRY_INDEX_BITS'($urandom_range(0, 15)),
                                   lec_pkg::TIME_BITS'($urandom_range(0, 16'hFFFF))));
      wait_drained();
   endtask

   task automatic test_random_phases();
      int unsigned                   mode_sel;
      int unsigned                   table_len;
      logic [lec_pkg::TIME_BITS-1:0] noise;
      for (int p = 0; p < PHASE_COUNT; p++) begin
         wait_drained();
         idle_max = ($urandom_range(0, 3) == 0) ? 0 : MAX_IDLE;
         mode_sel = (p < 8) ? p : $urandom_range(0, 5);
         if (p == 6) mode_sel = 32'(LED_MODE_UNUSED_LO);
         noise = lec_pkg::TIME_BITS'($urandom_range(0, 16'hFFFF));
         write_register(lec_pkg::CSR_TIME_ON, pick_duration(6));
         write_register(lec_pkg::CSR_TIME_OFF, pick_duration(6));
         write_register(lec_pkg::CSR_BREATHE_PERIOD, pick_duration(3));
         write_register(lec_pkg::CSR_PULSE_LENGTH, pick_duration(10));
         case ($urandom_range(0, 3))
            0:       write_register(lec_pkg::CSR_PWM_LEVEL, {noise[15:8], 8'h00});
            1:       write_register(lec_pkg::CSR_PWM_LEVEL, {noise[15:8], 8'hFF});
            default: write_register(lec_pkg::CSR_PWM_LEVEL, noise);
         endcase
         noise = lec_pkg::TIME_BITS'($urandom_range(0, 16'hFFFF));
         write_register(lec_pkg::CSR_LED_MODE,
                        {noise[15:lec_pkg::LED_MODE_BITS],
                         mode_sel[lec_pkg::LED_MODE_BITS-1:0]});
         if (mode_sel == lec_pkg::MODE_PATTERN) begin
            table_len = $urandom_range(1, lec_pkg::PATTERN_DEPTH);
            for (int j = 0; j < lec_pkg::PATTERN_DEPTH; j++)
               send_request(make_request(lec_pkg::CMD_LOAD,
                                         lec_pkg::ENTRY_INDEX_BITS'(j),
                                         (j < table_len) ?
                                         lec_pkg::TIME_BITS'($urandom_range(1, 4)) : '0));
         end
         if (mode_sel == lec_pkg::MODE_PATTERN || mode_sel == lec_pkg::MODE_PULSE)
            send_request(make_request(lec_pkg::CMD_START, '0, '0));
         for (int i = 0; i < PHASE_REQUESTS; i++) begin
            // hold off the sender until the response queue empties
            if (i == PHASE_REQUESTS / 2) wait_drained();
            send_request(random_request());
         end
         phases_run++;
      end
      wait_drained();
   endtask

   initial begin : response_checker
      lec_pkg::rsp_payload_type want;
      int unsigned              gap;
      wait (reset === 1'b0);
      forever begin
         gap = $urandom_range(0, idle_max);
         if (gap > 0) begin
            rsp_ready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         @(posedge clock);
         while (rsp_valid !== 1'b1) @(posedge clock);
         if (expected_responses.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10)
               $display("unexpected response: lit=%0b duty=%0d active=%0b busy=%0b",
                        rsp_data.led_lit, rsp_data.pwm_duty, rsp_data.pwm_active,
                        rsp_data.effect_busy);
         end else begin
            want = expected_responses.pop_front();
            responses_checked++;
            if (rsp_data.led_lit !== want.led_lit || rsp_data.pwm_duty !== want.pwm_duty ||
                rsp_data.pwm_active !== want.pwm_active ||
                rsp_data.effect_busy !== want.effect_busy) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("response %0d: expected %0b/%0d/%0b/%0b, got %0b/%0d/%0b/%0b",
                           responses_checked, want.led_lit, want.pwm_duty, want.pwm_active,
                           want.effect_busy, rsp_data.led_lit, rsp_data.pwm_duty,
                           rsp_data.pwm_active, rsp_data.effect_busy);
            end
         end
      end
   end

   initial begin : watchdog
      #10_000_000;
      $display("led_effect_controller_core regression: fail");
      $finish;
   end

   initial begin : main_sequence
      int unsigned drain_cycles;
      reset_led_model();
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      test_register_defaults();
      test_directed_commands();
      test_long_off_time();
      test_breathe_bounce();
      test_random_phases();
      req_valid <= 1'b0;
      drain_cycles = 0;
      while (expected_responses.size() != 0 && drain_cycles < 5000) begin
         @(posedge clock);
         drain_cycles++;
      end
      repeat (10) @(posedge clock);
      if (expected_responses.size() != 0) begin
         $display("%0d responses never arrived", expected_responses.size());
         mismatch_count += expected_responses.size();
      end
      $display("sent %0d requests over all LED modes, %0d random configuration phases",
               requests_sent, phases_run);
      $display("checked %0d responses, %0d errors", responses_checked, mismatch_count);
      if (mismatch_count == 0) begin
         $display("led_effect_controller_core regression: pass");
      end else begin
         $display("led_effect_controller_core regression: fail");
      end
      $finish;
   end

endmodule
